@@ hw/rtl/emulated_memory_map_decoder_defines.svh @@
// assertion macros used by the memory map decoder top level
`ifndef EMULATED_MEMORY_MAP_DECODER_DEFINES_SVH
`define EMULATED_MEMORY_MAP_DECODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EMM_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// delayed implication, timed to land at the pipeline output
`define EMM_ASSERT_LATENCY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/emm_pkg.sv @@
// shared types, constants and helpers of the memory map decoder
package emm_pkg;

  localparam logic [31:0] SOUND_BYTES       = 32'd740;
  localparam logic [2:0]  USER_PROGRAM_CODE = 3'd2;
  localparam logic [1:0]  KIND_FETCH        = 2'd2;

  localparam logic [15:0] HIGH_PAGE      = 16'hFFFF;
  localparam logic [31:0] ADDR24_MASK    = 32'h00FF_FFFF;
  localparam logic [15:0] ROM_PAGE       = 16'h0040;
  localparam logic [31:0] VECTOR_LIMIT   = 32'd1024;
  localparam logic [31:0] OS_LOW_LIMIT   = 32'd3072;
  localparam logic [10:0] OS_LOW_MASK    = 11'h7FF;
  localparam logic [10:0] OS_LOW_WINDOW  = 11'd1024;
  localparam logic [7:0]  VIA_PAGE       = 8'hEF;

  localparam logic [3:0] REGION_ALLOC      = 4'd0;
  localparam logic [3:0] REGION_SCREEN     = 4'd1;
  localparam logic [3:0] REGION_ALT_SCREEN = 4'd2;
  localparam logic [3:0] REGION_SOUND      = 4'd3;
  localparam logic [3:0] REGION_ROM        = 4'd4;
  localparam logic [3:0] REGION_OS_LOW     = 4'd5;
  localparam logic [3:0] REGION_LOW_MEM    = 4'd6;
  localparam logic [3:0] REGION_VIA        = 4'd7;
  localparam logic [3:0] REGION_CALLOUT    = 4'd8;
  localparam logic [3:0] REGION_DENIED     = 4'd9;

  localparam logic [2:0] CFG_ALLOC_START      = 3'd0;
  localparam logic [2:0] CFG_ALLOC_LIMIT      = 3'd1;
  localparam logic [2:0] CFG_MAIN_SCREEN_BASE = 3'd2;
  localparam logic [2:0] CFG_ALT_SCREEN_BASE  = 3'd3;
  localparam logic [2:0] CFG_SOUND_BASE       = 3'd4;
  localparam logic [2:0] CFG_SCREEN_BYTES     = 3'd5;
  localparam logic [2:0] CFG_LOW_MEMORY_BYTES = 3'd6;

  localparam logic [31:0] RST_ALLOC_START      = 32'h0000_0000;
  localparam logic [31:0] RST_ALLOC_LIMIT      = 32'h0000_0000;
  localparam logic [31:0] RST_MAIN_SCREEN_BASE = 32'h0001_A700;
  localparam logic [31:0] RST_ALT_SCREEN_BASE  = 32'h0001_2700;
  localparam logic [31:0] RST_SOUND_BASE       = 32'h0001_FD00;
  localparam logic [23:0] RST_SCREEN_BYTES     = 24'd21888;
  localparam logic [23:0] RST_LOW_MEMORY_BYTES = 24'd65536;

  typedef struct packed {
    logic [31:0] alloc_start;
    logic [31:0] alloc_limit;
    logic [31:0] main_screen_base;
    logic [31:0] alt_screen_base;
    logic [31:0] sound_base;
    logic [23:0] screen_bytes;
    logic [23:0] low_memory_bytes;
  } emm_cfg_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] len;
    logic        user;
    logic        fetch;
  } emm_access_t;

  typedef struct packed {
    logic        alloc;
    logic        screen;
    logic        alt_screen;
    logic        sound;
    logic        rom;
    logic        os_low;
    logic        low_mem;
    logic        low_deny;
    logic        via;
    logic [31:0] addr;
    logic [31:0] screen_off;
    logic [31:0] alt_off;
    logic [31:0] sound_off;
  } emm_hits_t;

  // span end formed at 33 bits so it never wraps
  function automatic logic in_span(logic [31:0] a, logic [31:0] base, logic [31:0] size);
    logic [32:0] span_end;
    span_end = {1'b0, base} + {1'b0, size};
    return (a >= base) && ({1'b0, a} < span_end);
  endfunction

endpackage

@@ hw/rtl/emulated_memory_map_decoder.sv @@
// top level of the emulated 68000 memory map decoder
// Takes one access per clock whenever start is high and busy is low; busy is
// high only while reset is held. Each access yields exactly one transaction on
// out_valid/out_region/out_offset, in order. The result reaches the ports once
// the access has passed the three register stages. It is shown for one cycle
// only and cannot be held off by the receiver. The register stages are: input
// capture with 24-bit address masking, the parallel region compares and offset
// subtractions, and the priority pick.
// Configuration writes take effect at the edge that writes them and should only
// be issued while no access is in flight.
`include "emulated_memory_map_decoder_defines.svh"

module emulated_memory_map_decoder import emm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_address,
  input  logic [31:0] in_span_length,
  input  logic [2:0]  in_function_code,
  input  logic [1:0]  in_access_kind,
  output logic        out_valid,
  output logic [3:0]  out_region,
  output logic [31:0] out_offset,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  emm_cfg_t    cfg;
  logic        acc_valid_r;
  emm_access_t acc_r;
  emm_access_t acc_nxt;
  logic        hits_valid;
  emm_hits_t   hits;
  logic        out_denied;

  assign busy = !rst_n;

  always_comb begin
    acc_nxt.addr  = (in_address[31:16] == HIGH_PAGE) ? in_address
                                                     : (in_address & ADDR24_MASK);
    acc_nxt.len   = in_span_length;
    acc_nxt.user  = (in_function_code <= USER_PROGRAM_CODE);
    acc_nxt.fetch = (in_access_kind == KIND_FETCH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_valid_r <= 1'b0;
    end else begin
      acc_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end

  emm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  emm_compare u_compare (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc_valid  (acc_valid_r),
    .acc        (acc_r),
    .cfg        (cfg),
    .hits_valid (hits_valid),
    .hits       (hits)
  );

  emm_select u_select (
    .clk        (clk),
    .rst_n      (rst_n),
    .hits_valid (hits_valid),
    .hits       (hits),
    .out_valid  (out_valid),
    .out_region (out_region),
    .out_offset (out_offset)
  );

  assign out_denied = out_valid && (out_region == REGION_DENIED);

  `EMM_ASSERT_LATENCY(a_one_result_per_access, start && !busy, out_valid, "access without result")
  `EMM_ASSERT_IMPLY(a_denied_zero_offset, out_denied, out_offset == '0, "denied with offset")
  `EMM_ASSERT_IMPLY(a_region_in_range, out_valid, out_region <= REGION_DENIED, "region out of range")
  `EMM_ASSERT_IMPLY(a_stage_valid_chain, out_valid, $past(hits_valid), "orphan result")

endmodule

@@ hw/rtl/emm_cfg.sv @@
// configuration register file of the memory map decoder
module emm_cfg import emm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output emm_cfg_t    cfg
);

  emm_cfg_t cfg_r;
  emm_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ALLOC_START:      cfg_nxt.alloc_start      = cfg_data;
        CFG_ALLOC_LIMIT:      cfg_nxt.alloc_limit      = cfg_data;
        CFG_MAIN_SCREEN_BASE: cfg_nxt.main_screen_base = cfg_data;
        CFG_ALT_SCREEN_BASE:  cfg_nxt.alt_screen_base  = cfg_data;
        CFG_SOUND_BASE:       cfg_nxt.sound_base       = cfg_data;
        CFG_SCREEN_BYTES:     cfg_nxt.screen_bytes     = cfg_data[23:0];
        CFG_LOW_MEMORY_BYTES: cfg_nxt.low_memory_bytes = cfg_data[23:0];
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alloc_start      <= RST_ALLOC_START;
      cfg_r.alloc_limit      <= RST_ALLOC_LIMIT;
      cfg_r.main_screen_base <= RST_MAIN_SCREEN_BASE;
      cfg_r.alt_screen_base  <= RST_ALT_SCREEN_BASE;
      cfg_r.sound_base       <= RST_SOUND_BASE;
      cfg_r.screen_bytes     <= RST_SCREEN_BYTES;
      cfg_r.low_memory_bytes <= RST_LOW_MEMORY_BYTES;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/emm_compare.sv @@
// second stage: region range compares and base-relative offsets
module emm_compare import emm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        acc_valid,
  input  emm_access_t acc,
  input  emm_cfg_t    cfg,
  output logic        hits_valid,
  output emm_hits_t   hits
);

  logic        valid_r;
  emm_hits_t   hits_r;
  emm_hits_t   hits_nxt;
  logic [31:0] low_bytes;
  logic [31:0] low_room;

  always_comb begin
    low_bytes = {8'b0, cfg.low_memory_bytes};
    low_room  = low_bytes - acc.len;

    hits_nxt.addr       = acc.addr;
    hits_nxt.alloc      = (acc.addr >= cfg.alloc_start) && (acc.addr < cfg.alloc_limit);
    hits_nxt.screen     = in_span(acc.addr, cfg.main_screen_base, {8'b0, cfg.screen_bytes});
    hits_nxt.alt_screen = in_span(acc.addr, cfg.alt_screen_base, {8'b0, cfg.screen_bytes});
    hits_nxt.sound      = in_span(acc.addr, cfg.sound_base, SOUND_BYTES);
    hits_nxt.rom        = (acc.addr[31:16] == ROM_PAGE);
    hits_nxt.os_low     = (acc.addr < OS_LOW_LIMIT)
                        && ((acc.addr[10:0] & OS_LOW_MASK) < OS_LOW_WINDOW)
                        && acc.user && !acc.fetch;
    hits_nxt.low_mem    = (acc.addr < low_bytes);
    hits_nxt.low_deny   = ((acc.addr < VECTOR_LIMIT) && (acc.user || acc.fetch))
                        || (acc.len > low_bytes) || (acc.addr > low_room);
    hits_nxt.via        = (acc.addr[23:16] == VIA_PAGE);
    hits_nxt.screen_off = acc.addr - cfg.main_screen_base;
    hits_nxt.alt_off    = acc.addr - cfg.alt_screen_base;
    hits_nxt.sound_off  = acc.addr - cfg.sound_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    hits_r <= hits_nxt;
  end

  assign hits_valid = valid_r;
  assign hits       = hits_r;

endmodule

@@ hw/rtl/emm_select.sv @@
// third stage: priority pick of region and offset
module emm_select import emm_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hits_valid,
  input  emm_hits_t   hits,
  output logic        out_valid,
  output logic [3:0]  out_region,
  output logic [31:0] out_offset
);

  logic        valid_r;
  logic [3:0]  region_r;
  logic [3:0]  region_nxt;
  logic [31:0] offset_r;
  logic [31:0] offset_nxt;

  always_comb begin
    region_nxt = REGION_CALLOUT;
    offset_nxt = hits.addr;
    priority if (hits.alloc) begin
      region_nxt = REGION_ALLOC;
    end else if (hits.screen) begin
      region_nxt = REGION_SCREEN;
      offset_nxt = hits.screen_off;
    end else if (hits.alt_screen) begin
      region_nxt = REGION_ALT_SCREEN;
      offset_nxt = hits.alt_off;
    end else if (hits.sound) begin
      region_nxt = REGION_SOUND;
      offset_nxt = hits.sound_off;
    end else if (hits.rom) begin
      region_nxt = REGION_ROM;
    end else if (hits.os_low) begin
      region_nxt = REGION_OS_LOW;
    end else if (hits.low_mem && hits.low_deny) begin
      region_nxt = REGION_DENIED;
      offset_nxt = '0;
    end else if (hits.low_mem) begin
      region_nxt = REGION_LOW_MEM;
    end else if (hits.via) begin
      region_nxt = REGION_VIA;
    end else begin
      region_nxt = REGION_CALLOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= hits_valid;
    end
  end

  always_ff @(posedge clk) begin
    region_r <= region_nxt;
    offset_r <= offset_nxt;
  end

  assign out_valid  = valid_r;
  assign out_region = region_r;
  assign out_offset = offset_r;

endmodule
